FILE: src/char_lcd_nibble_sequencer_top_defines.svh
// Assertion macros shared by the character-LCD nibble sequencer RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define CLNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CLNS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: src/clns_pkg.sv
// Shared types and constants for the character-LCD nibble sequencer.
// No dependencies.
`timescale 1ns / 1ps

package clns_pkg;

  // Request opcodes
  localparam logic [2:0] OpInit   = 3'd0;
  localparam logic [2:0] OpInstr  = 3'd1;
  localparam logic [2:0] OpChar   = 3'd2;
  localparam logic [2:0] OpCursor = 3'd3;
  localparam logic [2:0] OpClear  = 3'd4;
  localparam logic [2:0] OpHome   = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] RegFunctionSet   = 2'd0;
  localparam logic [1:0] RegDisplayCtrl   = 2'd1;
  localparam logic [1:0] RegEntryMode     = 2'd2;
  localparam logic [1:0] RegLongWait      = 2'd3;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [7:0]  FunctionSetRst = 8'd40;
  localparam logic [7:0]  DisplayCtrlRst = 8'd14;
  localparam logic [7:0]  EntryModeRst   = 8'd6;
  localparam logic [15:0] LongWaitRst    = 16'd2000;

  // Instructions and cursor bases
  localparam logic [7:0] InstClear = 8'h01;
  localparam logic [7:0] InstHome  = 8'h02;
  localparam logic [7:0] Row1Base  = 8'h80;
  localparam logic [7:0] Row2Base  = 8'hC0;
  localparam logic [5:0] MaxColumn = 6'd40;

  // Power-up raw nibbles and waits
  localparam logic [3:0]  WakeNibble     = 4'h3;
  localparam logic [3:0]  FourBitNibble  = 4'h2;
  localparam logic [15:0] PowerWaitUs    = 16'd40000;
  localparam logic [15:0] SecondWaitUs   = 16'd5000;
  localparam logic [15:0] ThirdWaitUs    = 16'd150;

  // Init makes 12 transfers, every other request 2
  localparam int InitSteps = 12;
  localparam int StepW     = $clog2(InitSteps);

  // Command queue between front and back
  localparam int QDepth = 2;
  localparam int PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW   = $clog2(QDepth + 1);

  // One classified request
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
    logic       long_post;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  function_set;
    logic [7:0]  display_ctrl;
    logic [7:0]  entry_mode;
    logic [15:0] long_wait;
  } cfg_t;

  // One nibble transfer
  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] pre_wait;
    logic [15:0] post_wait;
    logic        last;
  } xfer_t;

endpackage

FILE: src/clns_front.sv
// Front end: classifies requests into queue commands, drops requests with no output.
// Depends on clns_pkg.
`timescale 1ns / 1ps

module clns_front
  import clns_pkg::*;
(
  input  logic       push,
  input  logic       full,
  input  logic [2:0] op_i,
  input  logic [7:0] data_byte_i,
  input  logic [1:0] row_i,
  input  logic [5:0] column_i,
  output logic       wr_en_o,
  output cmd_t       wr_cmd_o
);

  logic       keep;
  logic [5:0] col_m1;
  logic [7:0] cursor_byte;

  always_comb begin
    if (column_i == 6'd0) begin
      col_m1 = 6'd0;
    end else if (column_i > MaxColumn) begin
      col_m1 = MaxColumn - 6'd1;
    end else begin
      col_m1 = column_i - 6'd1;
    end
    cursor_byte = ((row_i == 2'd1) ? Row1Base : Row2Base) | {2'b00, col_m1};
  end

  always_comb begin
    keep     = 1'b1;
    wr_cmd_o = '{is_init: 1'b0, rs: 1'b0, data: data_byte_i, long_post: 1'b0};
    case (op_i)
      OpInit: begin
        wr_cmd_o.is_init = 1'b1;
      end
      OpInstr: begin
        wr_cmd_o.data = data_byte_i;
      end
      OpChar: begin
        wr_cmd_o.rs = 1'b1;
      end
      OpCursor: begin
        wr_cmd_o.data = cursor_byte;
        keep          = (row_i == 2'd1) || (row_i == 2'd2);
      end
      OpClear: begin
        wr_cmd_o.data      = InstClear;
        wr_cmd_o.long_post = 1'b1;
      end
      OpHome: begin
        wr_cmd_o.data      = InstHome;
        wr_cmd_o.long_post = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Drop requests that make no transfer
  assign wr_en_o = push && !full && keep;

endmodule

FILE: src/clns_fifo.sv
// Short command queue between front and back end.
// Depends on clns_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_top_defines.svh"

module clns_fifo
  import clns_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_cmd_i,
  input  logic rd_en_i,
  output logic valid_o,
  output cmd_t rd_cmd_o,
  output logic full_o
);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(QDepth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign valid_o  = (cnt_q != '0);
  assign full_o   = (cnt_q == CntW'(QDepth));
  assign rd_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_en_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd_en_i && !wr_en_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  `CLNS_ASSERT(a_cnt_bound, cnt_q <= CntW'(QDepth), "queue count above depth")
  `CLNS_ASSERT(a_no_overflow, !(wr_en_i && full_o), "write into full queue")
  `CLNS_ASSERT(a_no_underflow, !(rd_en_i && !valid_o), "read from empty queue")

endmodule

FILE: src/clns_back.sv
// Back end: steps through the nibble transfers of the queue head into the result register.
// Depends on clns_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_top_defines.svh"

module clns_back
  import clns_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_rd_o,
  input  logic        pop,
  output logic        empty,
  output logic        reg_select_o,
  output logic [3:0]  nibble_o,
  output logic [15:0] pre_wait_us_o,
  output logic [15:0] post_wait_us_o,
  output logic        last_o
);

  logic             out_valid_q, out_valid_d;
  xfer_t            out_q;
  xfer_t            xfer;
  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] byte_pair;
  logic [7:0]       cur_byte;
  logic             load;

  // Transfer for the current step of the queue head
  always_comb begin
    byte_pair = step_q - StepW'(4);
    cur_byte  = q_cmd_i.data;
    xfer      = '{rs: q_cmd_i.rs, nibble: 4'h0, pre_wait: 16'd0, post_wait: 16'd0,
                  last: 1'b0};
    if (q_cmd_i.is_init) begin
      xfer.rs = 1'b0;
      case (byte_pair[StepW-1:1])
        3'd0:    cur_byte = cfg_i.function_set;
        3'd1:    cur_byte = cfg_i.display_ctrl;
        3'd2:    cur_byte = InstClear;
        default: cur_byte = cfg_i.entry_mode;
      endcase
      xfer.nibble = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
      if (byte_pair[StepW-1:1] == 3'd2 && step_q[0]) begin
        xfer.post_wait = cfg_i.long_wait;
      end
      xfer.last = (step_q == StepW'(InitSteps - 1));
      case (step_q)
        StepW'(0): begin
          xfer.nibble   = WakeNibble;
          xfer.pre_wait = PowerWaitUs;
        end
        StepW'(1): begin
          xfer.nibble   = WakeNibble;
          xfer.pre_wait = SecondWaitUs;
        end
        StepW'(2): begin
          xfer.nibble   = WakeNibble;
          xfer.pre_wait = ThirdWaitUs;
        end
        StepW'(3): begin
          xfer.nibble = FourBitNibble;
        end
        default: begin
        end
      endcase
    end else begin
      xfer.nibble = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
      if (step_q[0] && q_cmd_i.long_post) begin
        xfer.post_wait = cfg_i.long_wait;
      end
      xfer.last = step_q[0];
    end
  end

  // Advance when the result register is free or being drained
  assign load   = q_valid_i && (!out_valid_q || pop);
  assign q_rd_o = load && xfer.last;

  always_comb begin
    step_d = step_q;
    if (load) begin
      step_d = xfer.last ? '0 : step_q + StepW'(1);
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= xfer;
    end
  end

  assign empty          = !out_valid_q;
  assign reg_select_o   = out_q.rs;
  assign nibble_o       = out_q.nibble;
  assign pre_wait_us_o  = out_q.pre_wait;
  assign post_wait_us_o = out_q.post_wait;
  assign last_o         = out_q.last;

  `CLNS_ASSERT(a_step_bound, step_q < StepW'(InitSteps), "step past init length")
  `CLNS_ASSERT(a_short_step, (q_valid_i && !q_cmd_i.is_init) |-> (step_q <= StepW'(1)),
               "byte request step out of range")
  `CLNS_ASSERT(a_last_rewinds, (load && xfer.last) |=> (step_q == '0),
               "step not rewound after last transfer")

endmodule

FILE: src/char_lcd_nibble_sequencer_top.sv
// Character-LCD nibble sequencer, 4-bit interface: request in, nibble transfers out.
// A request passes the queue and then the result register to reach the result ports.
// Throughput: one transfer per cycle from the back-end step counter while the result
// register is free or popped; a byte request makes 2 transfers, init 12.
// Reset (rst_ni low, async) empties the queue and result register and restores the
// configuration registers to their defaults; no clearing pass.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_top
  import clns_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          op_i,
  input  logic [7:0]          data_byte_i,
  input  logic [1:0]          row_i,
  input  logic [5:0]          column_i,
  output logic                empty,
  input  logic                pop,
  output logic                reg_select_o,
  output logic [3:0]          nibble_o,
  output logic [15:0]         pre_wait_us_o,
  output logic [15:0]         post_wait_us_o,
  output logic                last_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  cmd_t wr_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_rd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFunctionSet: cfg_d.function_set = cfg_data_i[7:0];
        RegDisplayCtrl: cfg_d.display_ctrl = cfg_data_i[7:0];
        RegEntryMode:   cfg_d.entry_mode   = cfg_data_i[7:0];
        RegLongWait:    cfg_d.long_wait    = cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{function_set: FunctionSetRst, display_ctrl: DisplayCtrlRst,
                 entry_mode: EntryModeRst, long_wait: LongWaitRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  clns_front u_front (
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .wr_en_o     (wr_en),
    .wr_cmd_o    (wr_cmd)
  );

  clns_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_cmd_i (wr_cmd),
    .rd_en_i  (q_rd),
    .valid_o  (q_valid),
    .rd_cmd_o (q_cmd),
    .full_o   (full)
  );

  clns_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_rd_o         (q_rd),
    .pop            (pop),
    .empty          (empty),
    .reg_select_o   (reg_select_o),
    .nibble_o       (nibble_o),
    .pre_wait_us_o  (pre_wait_us_o),
    .post_wait_us_o (post_wait_us_o),
    .last_o         (last_o)
  );

endmodule
